// ===== sv/rfs_pkg.sv =====
`default_nettype none

package rfs_pkg;

    // field widths fixed by the item format
    localparam int CMD_W   = 2;
    localparam int VAL_W   = 32;
    localparam int SIZE_W  = 5;
    localparam int CONS_W  = 8;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // configuration reset values
    localparam logic [SIZE_W-1:0] BUF_SIZE_RST = 5'd16;
    localparam logic [CONS_W-1:0] NUM_CONS_RST = 8'd1;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_GET    = 2'd1,
        CMD_END    = 2'd2
    } t_cmd;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // register index, taken from paddr bit 2
    typedef enum logic {
        REG_BUFFER_SIZE   = 1'b0,
        REG_NUM_CONSUMERS = 1'b1
    } t_reg;

    // configuration handed from the register file to the datapath
    typedef struct packed {
        logic [SIZE_W-1:0] buffer_size;
        logic [CONS_W-1:0] num_consumers;
    } t_cfg;

    // control and statistics carried between the input and result registers
    typedef struct packed {
        t_status           status;
        logic              pop_ok;
        logic              end_final;
        logic [SIZE_W-1:0] occupancy;
        logic [CNT_W-1:0]  times_full;
        logic [CNT_W-1:0]  times_empty;
    } t_stage;

    // one result item
    typedef struct packed {
        t_status           status;
        logic [VAL_W-1:0]  out_value;
        logic              out_is_end_marker;
        logic              end_final;
        logic [SIZE_W-1:0] occupancy;
        logic [CNT_W-1:0]  times_full;
        logic [CNT_W-1:0]  times_empty;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/rfs_cmd_if.sv =====
`default_nettype none

interface rfs_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [rfs_pkg::CMD_W-1:0]   command;
    logic [rfs_pkg::VAL_W-1:0]   item_value;

    modport source (output valid, output command, output item_value, input ready);
    modport sink   (input valid, input command, input item_value, output ready);
endinterface

`default_nettype wire

// ===== sv/rfs_res_if.sv =====
`default_nettype none

interface rfs_res_if;
    logic                        valid;
    logic                        ready;
    logic [rfs_pkg::STAT_W-1:0]  status;
    logic [rfs_pkg::VAL_W-1:0]   out_value;
    logic                        out_is_end_marker;
    logic                        end_final;
    logic [rfs_pkg::SIZE_W-1:0]  occupancy;
    logic [rfs_pkg::CNT_W-1:0]   times_full;
    logic [rfs_pkg::CNT_W-1:0]   times_empty;

    modport source (
        output valid, output status, output out_value, output out_is_end_marker,
        output end_final, output occupancy, output times_full, output times_empty,
        input ready
    );
    modport sink (
        input valid, input status, input out_value, input out_is_end_marker,
        input end_final, input occupancy, input times_full, input times_empty,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/rfs_apb_regs.sv =====
`default_nettype none

module rfs_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfs_pkg::ADDR_W-1:0]    paddr,
    input  logic [rfs_pkg::DATA_W-1:0]    pwdata,
    output logic [rfs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output rfs_pkg::t_cfg                 o_cfg
);

    rfs_pkg::t_cfg r_cfg;
    logic          w_wr;
    rfs_pkg::t_reg w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = rfs_pkg::t_reg'(paddr[2]);

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer_size   <= rfs_pkg::BUF_SIZE_RST;
            r_cfg.num_consumers <= rfs_pkg::NUM_CONS_RST;
        end else if (w_wr) begin
            case (w_idx)
                rfs_pkg::REG_BUFFER_SIZE:
                    r_cfg.buffer_size <= pwdata[rfs_pkg::SIZE_W-1:0];
                rfs_pkg::REG_NUM_CONSUMERS:
                    r_cfg.num_consumers <= pwdata[rfs_pkg::CONS_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            rfs_pkg::REG_BUFFER_SIZE:
                prdata = rfs_pkg::DATA_W'(r_cfg.buffer_size);
            rfs_pkg::REG_NUM_CONSUMERS:
                prdata = rfs_pkg::DATA_W'(r_cfg.num_consumers);
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/ring_fifo_with_stats_and_end_marker.sv =====
// a result passes the stage register and the store read register, then the result register
// throughput: one command per cycle while results are taken; a stalled result holds the stages
// and the command input; the store is read at the transfer and feeds the result register
// reset: positions, occupancy, event counters and the end count clear to zero,
// buffer_size returns to 16 and num_consumers to 1; the entry store is not cleared
`default_nettype none

module ring_fifo_with_stats_and_end_marker #(
    parameter int MAX_DEPTH    = 16,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rfs_cmd_if.sink                       i_cmd,
    rfs_res_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfs_pkg::ADDR_W-1:0]    paddr,
    input  logic [rfs_pkg::DATA_W-1:0]    pwdata,
    output logic [rfs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int HW = (HANDLE_WIDTH < rfs_pkg::VAL_W) ? HANDLE_WIDTH : rfs_pkg::VAL_W;
    localparam int DW = HW + 1;
    localparam int SW = rfs_pkg::SIZE_W;
    localparam int CW = rfs_pkg::CNT_W;
    localparam int EW = rfs_pkg::CONS_W;

    rfs_pkg::t_cfg w_cfg;

    rfs_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // fifo state
    logic [AW-1:0]   r_wr_pos, n_wr_pos;
    logic [AW-1:0]   r_rd_pos, n_rd_pos;
    logic [SW-1:0]   r_held, n_held;
    logic [CW-1:0]   r_full_cnt, n_full_cnt;
    logic [CW-1:0]   r_empty_cnt, n_empty_cnt;
    logic [EW-1:0]   r_ends, n_ends;

    // entry store and its read register
    logic [DW-1:0]   r_mem [MAX_DEPTH];
    logic [DW-1:0]   r_rd_data;
    logic [DW-1:0]   w_wdata;

    // pipeline
    logic            r_s1_v;
    rfs_pkg::t_stage r_s1, n_s1;
    logic            r_o_v;
    rfs_pkg::t_result r_o, n_o;

    logic            w_acc;
    logic            w_s1_adv;
    logic [SW-1:0]   w_act;
    logic            w_full;
    logic            w_empty;
    logic            w_push;
    logic            w_push_end;
    logic            w_pop;
    logic [AW-1:0]   w_wr_next;
    logic [AW-1:0]   w_rd_next;
    logic [EW:0]     w_seen;

    // handshake
    assign w_s1_adv    = !r_o_v || o_res.ready;
    assign i_cmd.ready = !r_s1_v || w_s1_adv;
    assign w_acc       = i_cmd.valid && i_cmd.ready;

    // active size, clamped to 1..MAX_DEPTH
    always_comb begin
        if (w_cfg.buffer_size == '0) begin
            w_act = SW'(1);
        end else if (32'(w_cfg.buffer_size) > 32'(MAX_DEPTH)) begin
            w_act = SW'(MAX_DEPTH);
        end else begin
            w_act = w_cfg.buffer_size;
        end
    end

    assign w_full  = (r_held >= w_act);
    assign w_empty = (r_held == '0);

    // position successors, wrapping at the active size
    assign w_wr_next = ((32'(r_wr_pos) + 32'd1) >= 32'(w_act)) ? '0 : r_wr_pos + AW'(1);
    assign w_rd_next = ((32'(r_rd_pos) + 32'd1) >= 32'(w_act)) ? '0 : r_rd_pos + AW'(1);
    assign w_seen    = {1'b0, r_ends} + (EW+1)'(1);

    // command decode and next state
    always_comb begin
        w_push      = 1'b0;
        w_push_end  = 1'b0;
        w_pop       = 1'b0;
        n_wr_pos    = r_wr_pos;
        n_rd_pos    = r_rd_pos;
        n_held      = r_held;
        n_full_cnt  = r_full_cnt;
        n_empty_cnt = r_empty_cnt;
        n_ends      = r_ends;
        n_s1.status    = rfs_pkg::ST_DONE;
        n_s1.end_final = 1'b0;

        case (i_cmd.command)
            rfs_pkg::CMD_INSERT: begin
                if (w_full) begin
                    n_s1.status = rfs_pkg::ST_FULL;
                end else begin
                    w_push = 1'b1;
                end
            end
            rfs_pkg::CMD_GET: begin
                if (w_empty) begin
                    n_s1.status = rfs_pkg::ST_EMPTY;
                end else begin
                    w_pop = 1'b1;
                end
            end
            rfs_pkg::CMD_END: begin
                if (w_seen < {1'b0, w_cfg.num_consumers}) begin
                    if (w_full) begin
                        n_s1.status = rfs_pkg::ST_FULL;
                    end else begin
                        w_push     = 1'b1;
                        w_push_end = 1'b1;
                        n_ends     = w_seen[EW-1:0];
                    end
                end else begin
                    n_s1.end_final = 1'b1;
                    if (r_ends != '1) begin
                        n_ends = w_seen[EW-1:0];
                    end
                end
            end
            default: ;
        endcase

        // push side, counting fills
        if (w_push) begin
            n_wr_pos = w_wr_next;
            n_held   = r_held + SW'(1);
            if ((r_held + SW'(1)) == w_act && r_full_cnt != '1) begin
                n_full_cnt = r_full_cnt + CW'(1);
            end
        end

        // pop side, counting drains
        if (w_pop) begin
            n_rd_pos = w_rd_next;
            n_held   = r_held - SW'(1);
            if (r_held == SW'(1) && r_empty_cnt != '1) begin
                n_empty_cnt = r_empty_cnt + CW'(1);
            end
        end

        n_s1.pop_ok      = w_pop;
        n_s1.occupancy   = n_held;
        n_s1.times_full  = n_full_cnt;
        n_s1.times_empty = n_empty_cnt;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
            r_held      <= '0;
            r_full_cnt  <= '0;
            r_empty_cnt <= '0;
            r_ends      <= '0;
        end else if (w_acc) begin
            r_wr_pos    <= n_wr_pos;
            r_rd_pos    <= n_rd_pos;
            r_held      <= n_held;
            r_full_cnt  <= n_full_cnt;
            r_empty_cnt <= n_empty_cnt;
            r_ends      <= n_ends;
        end
    end

    // end markers are stored with a zero handle
    assign w_wdata = w_push_end ? {1'b1, {HW{1'b0}}} : {1'b0, i_cmd.item_value[HW-1:0]};

    // entry store: one write or one registered read per cycle, only on an accepted command
    always_ff @(posedge i_clk) begin
        if (w_acc && w_push) begin
            r_mem[r_wr_pos] <= w_wdata;
        end
        if (w_acc && w_pop) begin
            r_rd_data <= r_mem[r_rd_pos];
        end
    end

    // stage after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_cmd.ready) begin
            r_s1_v <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1 <= n_s1;
        end
    end

    // assemble the result from the store read
    always_comb begin
        n_o.status            = r_s1.status;
        n_o.out_is_end_marker = r_s1.pop_ok && r_rd_data[HW];
        n_o.out_value         = (r_s1.pop_ok && !r_rd_data[HW])
                                ? rfs_pkg::VAL_W'(r_rd_data[HW-1:0]) : '0;
        n_o.end_final         = r_s1.end_final;
        n_o.occupancy         = r_s1.occupancy;
        n_o.times_full        = r_s1.times_full;
        n_o.times_empty       = r_s1.times_empty;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_s1_adv) begin
            r_o_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_v) begin
            r_o <= n_o;
        end
    end

    assign o_res.valid             = r_o_v;
    assign o_res.status            = r_o.status;
    assign o_res.out_value         = r_o.out_value;
    assign o_res.out_is_end_marker = r_o.out_is_end_marker;
    assign o_res.end_final         = r_o.end_final;
    assign o_res.occupancy         = r_o.occupancy;
    assign o_res.times_full        = r_o.times_full;
    assign o_res.times_empty       = r_o.times_empty;

    // a stalled stage keeps its control and, for a pop, its read data
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !w_s1_adv
        |=> r_s1_v && $stable(r_s1) && (!r_s1.pop_ok || $stable(r_rd_data)))
        else $error("stalled stage lost its contents");

    // an empty rejection reports an empty buffer and no handle
    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status == rfs_pkg::ST_EMPTY
        |-> o_res.occupancy == '0 && o_res.out_value == '0)
        else $error("empty rejection with entries held");

    // a full rejection never reports an empty buffer
    a_full_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status == rfs_pkg::ST_FULL |-> o_res.occupancy != '0)
        else $error("full rejection with no entries held");

    // an end marker comes only from a completed pop and carries no handle
    a_marker_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.out_is_end_marker
        |-> o_res.out_value == '0 && o_res.status == rfs_pkg::ST_DONE && !o_res.end_final)
        else $error("malformed end marker result");

endmodule

`default_nettype wire

// ===== bench/rfs_result_check.sv =====
`timescale 1ns / 1ps

module rfs_result_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  logic                          i_cmd_ready,
    input  logic [rfs_pkg::CMD_W-1:0]     i_command,
    input  logic [rfs_pkg::VAL_W-1:0]     i_item_value,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic [rfs_pkg::STAT_W-1:0]    i_status,
    input  logic [rfs_pkg::VAL_W-1:0]     i_out_value,
    input  logic                          i_out_is_end_marker,
    input  logic                          i_end_final,
    input  logic [rfs_pkg::SIZE_W-1:0]    i_occupancy,
    input  logic [rfs_pkg::CNT_W-1:0]     i_times_full,
    input  logic [rfs_pkg::CNT_W-1:0]     i_times_empty,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [rfs_pkg::ADDR_W-1:0]    paddr,
    input  logic [rfs_pkg::DATA_W-1:0]    pwdata,
    output int                            o_fail_count,
    output int                            o_outstanding
);

    localparam int DEPTH = 16;

    // shadow of the ring and its counters
    logic [rfs_pkg::VAL_W-1:0]  slot_val [DEPTH];
    logic                       slot_end [DEPTH];
    logic [3:0]                 wr_pos;
    logic [3:0]                 rd_pos;
    logic [rfs_pkg::SIZE_W-1:0] held;
    logic [rfs_pkg::CNT_W-1:0]  full_cnt;
    logic [rfs_pkg::CNT_W-1:0]  empty_cnt;
    logic [7:0]                 ends_seen;
    logic [rfs_pkg::SIZE_W-1:0] cfg_size;
    logic [rfs_pkg::CONS_W-1:0] cfg_cons;

    rfs_pkg::t_result predicted_results[$];
    int               errors = 0;

    // size register as the ring uses it: zero acts as one, clamp at depth
    function automatic logic [rfs_pkg::SIZE_W-1:0] live_size();
        if (cfg_size == '0) return rfs_pkg::SIZE_W'(1);
        if (cfg_size > DEPTH) return rfs_pkg::SIZE_W'(DEPTH);
        return cfg_size;
    endfunction

    function automatic logic [3:0] advance(logic [3:0] p);
        logic [rfs_pkg::SIZE_W-1:0] n;
        n = {1'b0, p} + 1'b1;
        if (n >= live_size()) n = '0;
        return n[3:0];
    endfunction

    function automatic logic [rfs_pkg::CNT_W-1:0] sat_inc(logic [rfs_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic bit push_entry(logic [rfs_pkg::VAL_W-1:0] handle, logic is_end);
        if (held >= live_size()) return 1'b0;
        slot_val[wr_pos] = handle;
        slot_end[wr_pos] = is_end;
        wr_pos = advance(wr_pos);
        held = held + 1'b1;
        if (held == live_size()) full_cnt = sat_inc(full_cnt);
        return 1'b1;
    endfunction

    // apply one command to the shadow ring and return the result it should give
    function automatic rfs_pkg::t_result fifo_step(logic [rfs_pkg::CMD_W-1:0] code,
                                                   logic [rfs_pkg::VAL_W-1:0] val);
        rfs_pkg::t_result r;
        logic [8:0]       next_ends;
        r = '0;
        r.status = rfs_pkg::ST_DONE;
        case (code)
            rfs_pkg::CMD_INSERT: begin
                if (!push_entry(val, 1'b0)) r.status = rfs_pkg::ST_FULL;
            end
            rfs_pkg::CMD_GET: begin
                if (held == '0) begin
                    r.status = rfs_pkg::ST_EMPTY;
                end else begin
                    r.out_is_end_marker = slot_end[rd_pos];
                    r.out_value = slot_end[rd_pos] ? '0 : slot_val[rd_pos];
                    rd_pos = advance(rd_pos);
                    held = held - 1'b1;
                    if (held == '0) empty_cnt = sat_inc(empty_cnt);
                end
            end
            rfs_pkg::CMD_END: begin
                next_ends = {1'b0, ends_seen} + 1'b1;
                if (next_ends < {1'b0, cfg_cons}) begin
                    if (push_entry('0, 1'b1)) ends_seen = next_ends[7:0];
                    else r.status = rfs_pkg::ST_FULL;
                end else begin
                    r.end_final = 1'b1;
                    if (ends_seen != 8'hFF) ends_seen = next_ends[7:0];
                end
            end
            default: ;
        endcase
        r.occupancy   = held;
        r.times_full  = full_cnt;
        r.times_empty = empty_cnt;
        return r;
    endfunction

    function automatic string fmt_result(rfs_pkg::t_result r);
        return $sformatf("st=%0d val=%h marker=%0b final=%0b occ=%0d full=%0d empty=%0d",
                         r.status, r.out_value, r.out_is_end_marker, r.end_final,
                         r.occupancy, r.times_full, r.times_empty);
    endfunction

    // compare result transfers first, then register writes, then predict commands
    always @(posedge i_clk) begin
        rfs_pkg::t_result got;
        rfs_pkg::t_result want;
        if (!i_rst_n) begin
            wr_pos    = '0;
            rd_pos    = '0;
            held      = '0;
            full_cnt  = '0;
            empty_cnt = '0;
            ends_seen = '0;
            cfg_size  = rfs_pkg::BUF_SIZE_RST;
            cfg_cons  = rfs_pkg::NUM_CONS_RST;
            predicted_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got.status            = rfs_pkg::t_status'(i_status);
                got.out_value         = i_out_value;
                got.out_is_end_marker = i_out_is_end_marker;
                got.end_final         = i_end_final;
                got.occupancy         = i_occupancy;
                got.times_full        = i_times_full;
                got.times_empty       = i_times_empty;
                if (predicted_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result: %s", fmt_result(got));
                end else begin
                    want = predicted_results.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("result mismatch: expected %s", fmt_result(want));
                            $display("                 actual   %s", fmt_result(got));
                        end
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (rfs_pkg::t_reg'(paddr[2]))
                    rfs_pkg::REG_BUFFER_SIZE:   cfg_size = pwdata[rfs_pkg::SIZE_W-1:0];
                    rfs_pkg::REG_NUM_CONSUMERS: cfg_cons = pwdata[rfs_pkg::CONS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd_valid && i_cmd_ready)
                predicted_results.push_back(fifo_step(i_command, i_item_value));
        end
        o_fail_count  <= errors;
        o_outstanding <= predicted_results.size();
    end

endmodule

// ===== bench/tb_ring_fifo_with_stats_and_end_marker.sv =====
`timescale 1ns / 1ps

module tb_ring_fifo_with_stats_and_end_marker;

    // command code the block must ignore
    localparam logic [rfs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 150;
    localparam int RX_HOLD_CYCLES = 80;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [rfs_pkg::ADDR_W-1:0] paddr;
    logic [rfs_pkg::DATA_W-1:0] pwdata;
    logic [rfs_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    int fail_count;
    int pending_results;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit rx_hold_req = 1'b0;
    bit fill_mode = 1'b1;

    logic [rfs_pkg::VAL_W-1:0] corner_vals [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                   32'h5555_5555, 32'hAAAA_AAAA};
    int phase_size [NUM_PHASES] = '{16, 4, 1, 31, 9, 2, 0, 16};
    int phase_cons [NUM_PHASES] = '{255, 255, 255, 255, 128, 1, 0, 0};
    int phase_ends [NUM_PHASES] = '{8, 8, 8, 8, 8, 8, 40, 70};

    rfs_cmd_if cmd_if ();
    rfs_res_if res_if ();

    ring_fifo_with_stats_and_end_marker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rfs_result_check result_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd_valid         (cmd_if.valid),
        .i_cmd_ready         (cmd_if.ready),
        .i_command           (cmd_if.command),
        .i_item_value        (cmd_if.item_value),
        .i_res_valid         (res_if.valid),
        .i_res_ready         (res_if.ready),
        .i_status            (res_if.status),
        .i_out_value         (res_if.out_value),
        .i_out_is_end_marker (res_if.out_is_end_marker),
        .i_end_final         (res_if.end_final),
        .i_occupancy         (res_if.occupancy),
        .i_times_full        (res_if.times_full),
        .i_times_empty       (res_if.times_empty),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .pready              (pready),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .o_fail_count        (fail_count),
        .o_outstanding       (pending_results)
    );

    // 50 MHz clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= !(rx_idle_on && $urandom_range(0, 99) < 36);
            end
        end
    end

    // offer one command and hold it until the transfer
    task automatic send_cmd(input logic [rfs_pkg::CMD_W-1:0] code,
                            input logic [rfs_pkg::VAL_W-1:0] val);
        while (tx_idle_on && $urandom_range(0, 99) < 36) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.command    <= code;
        cmd_if.item_value <= val;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input rfs_pkg::t_reg idx, input logic [rfs_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [rfs_pkg::SIZE_W-1:0] size_val,
                              input logic [rfs_pkg::CONS_W-1:0] cons_val);
        apb_write(rfs_pkg::REG_BUFFER_SIZE, rfs_pkg::DATA_W'(size_val));
        apb_write(rfs_pkg::REG_NUM_CONSUMERS, rfs_pkg::DATA_W'(cons_val));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // command mix: ends, unused codes, and bursts that lean toward filling or draining the ring
    function automatic logic [rfs_pkg::CMD_W-1:0] pick_cmd(int end_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < end_pct) return rfs_pkg::CMD_END;
        if (roll < end_pct + 3) return CMD_UNUSED;
        roll = $urandom_range(0, 99);
        if (fill_mode) return (roll < 70) ? rfs_pkg::CMD_INSERT : rfs_pkg::CMD_GET;
        return (roll < 70) ? rfs_pkg::CMD_GET : rfs_pkg::CMD_INSERT;
    endfunction

    initial begin
        i_rst_n           <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.command    <= rfs_pkg::CMD_INSERT;
        cmd_if.item_value <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every slot once (corner handles first), overflow, drain, underflow
        for (int k = 0; k < 16; k++)
            send_cmd(rfs_pkg::CMD_INSERT, (k < 4) ? corner_vals[k] : $urandom());
        send_cmd(rfs_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        send_cmd(rfs_pkg::CMD_END, '0);
        send_cmd(CMD_UNUSED, 32'h1234_5678);
        repeat (17) send_cmd(rfs_pkg::CMD_GET, $urandom());

        // size zero acts as one entry, zero consumers make every end final
        wait_drained();
        set_config(5'd0, 8'd0);
        send_cmd(rfs_pkg::CMD_INSERT, $urandom());
        send_cmd(rfs_pkg::CMD_INSERT, $urandom());
        send_cmd(rfs_pkg::CMD_END, $urandom());
        send_cmd(rfs_pkg::CMD_GET, $urandom());
        send_cmd(rfs_pkg::CMD_GET, $urandom());

        // end marker pushed, then an end against a full ring
        wait_drained();
        set_config(5'd2, 8'd255);
        send_cmd(rfs_pkg::CMD_INSERT, $urandom());
        send_cmd(rfs_pkg::CMD_END, $urandom());
        send_cmd(rfs_pkg::CMD_END, $urandom());
        send_cmd(rfs_pkg::CMD_GET, $urandom());
        send_cmd(rfs_pkg::CMD_GET, $urandom());
        send_cmd(rfs_pkg::CMD_GET, $urandom());

        // oversized register clamps, then shrink the ring while it holds entries
        wait_drained();
        set_config(5'd31, 8'd255);
        repeat (5) send_cmd(rfs_pkg::CMD_INSERT, $urandom());
        wait_drained();
        set_config(5'd3, 8'd255);
        send_cmd(rfs_pkg::CMD_INSERT, $urandom());
        repeat (6) send_cmd(rfs_pkg::CMD_GET, $urandom());

        // random phases over a spread of sizes and consumer counts
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            set_config(rfs_pkg::SIZE_W'(phase_size[p]), rfs_pkg::CONS_W'(phase_cons[p]));
            tx_idle_on = (p != 1);
            rx_idle_on = (p != 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 && k == 40) rx_hold_req = 1'b1;
                if (p == 0 && k == 100) wait_drained();
                if ($urandom_range(0, 11) == 0) fill_mode = !fill_mode;
                send_cmd(pick_cmd(phase_ends[p]), $urandom());
            end
        end

        // let the last results drain, then allow for late extra transfers
        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
